### rtl/mfhp_pkg.sv
// Shared types, codes and helpers of the MAC frame header parser.
`default_nettype none

package mfhp_pkg;

    localparam int unsigned MAX_PAYLOAD = 255;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Address mode codes in the frame control word.
    localparam logic [1:0] AM_NONE  = 2'd0;
    localparam logic [1:0] AM_SHORT = 2'd2;

    typedef enum logic [2:0] {
        PH_CTL0    = 3'd0,
        PH_CTL1    = 3'd1,
        PH_SEQ     = 3'd2,
        PH_DPAN    = 3'd3,
        PH_DADDR   = 3'd4,
        PH_SPAN    = 3'd5,
        PH_SADDR   = 3'd6,
        PH_PAYLOAD = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TRUNC    = 2'd1,
        ST_SECURITY = 2'd2,
        ST_TOO_LONG = 2'd3
    } status_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [15:0] control_word;
        logic [7:0]  sequence_number;
        logic [15:0] dest_pan;
        logic [63:0] dest_address;
        logic [15:0] source_pan;
        logic [63:0] source_address;
        logic [7:0]  payload_length;
        logic [15:0] check_sequence;
        status_t     status;
    } result_t;

    // Up to two results per accepted byte; the first slot is filled first.
    typedef struct packed {
        logic    push0;
        logic    push1;
        result_t res0;
        result_t res1;
    } push_t;

    function automatic logic [1:0] dest_mode(input logic [15:0] ctl);
        return ctl[11:10];
    endfunction

    function automatic logic [1:0] src_mode(input logic [15:0] ctl);
        return ctl[15:14];
    endfunction

    function automatic logic pan_comp(input logic [15:0] ctl);
        return ctl[6];
    endfunction

    function automatic logic security_on(input logic [15:0] ctl);
        return ctl[3];
    endfunction

    // Reserved mode is parsed like an extended address.
    function automatic logic [3:0] addr_len(input logic [1:0] mode);
        logic [3:0] len;
        if (mode == AM_NONE)
            len = 4'd0;
        else if (mode == AM_SHORT)
            len = 4'd2;
        else
            len = 4'd8;
        return len;
    endfunction

    function automatic phase_t source_start(input logic [15:0] ctl);
        phase_t ph;
        if (src_mode(ctl) == AM_NONE)
            ph = PH_PAYLOAD;
        else if (pan_comp(ctl))
            ph = PH_SADDR;
        else
            ph = PH_SPAN;
        return ph;
    endfunction

endpackage

`default_nettype wire

### rtl/mfhp_parser.sv
// Per-byte header parser with payload delay line and frame summary build.
`default_nettype none

module mfhp_parser #(
    parameter int unsigned MAX_PAYLOAD = mfhp_pkg::MAX_PAYLOAD
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_we,
    input  wire logic           cfg_wdata,
    input  wire logic           accept,
    input  wire logic [7:0]     frame_byte,
    input  wire logic           frame_end,
    output mfhp_pkg::push_t     push
);
    import mfhp_pkg::*;

    logic        fcs_present_reg;
    phase_t      phase_reg, phase_next;
    logic [2:0]  pos_reg, pos_next;
    logic [15:0] control_reg, control_next;
    logic [7:0]  seqno_reg, seqno_next;
    logic [15:0] dest_pan_reg, dest_pan_next;
    logic [63:0] dest_addr_reg, dest_addr_next;
    logic [15:0] source_pan_reg, source_pan_next;
    logic [63:0] source_addr_reg, source_addr_next;
    logic [7:0]  tail0_reg, tail0_next;
    logic [7:0]  tail1_reg, tail1_next;
    logic [1:0]  fill_reg, fill_next;
    logic [7:0]  count_reg, count_next;
    logic        too_long_reg, too_long_next;

    logic [3:0]  pos_inc;
    logic        emit;
    logic [7:0]  emit_byte;
    result_t     pay_res;
    result_t     sum_res;

    always_comb
    begin
        phase_next       = phase_reg;
        pos_next         = pos_reg;
        control_next     = control_reg;
        seqno_next       = seqno_reg;
        dest_pan_next    = dest_pan_reg;
        dest_addr_next   = dest_addr_reg;
        source_pan_next  = source_pan_reg;
        source_addr_next = source_addr_reg;
        tail0_next       = tail0_reg;
        tail1_next       = tail1_reg;
        fill_next        = fill_reg;
        count_next       = count_reg;
        too_long_next    = too_long_reg;
        emit             = 1'b0;
        emit_byte        = 8'h00;
        pos_inc          = {1'b0, pos_reg} + 4'd1;
        pay_res          = '0;
        sum_res          = '0;
        push             = '0;

        if (accept)
        begin
            unique case (phase_reg)
                PH_CTL0:
                begin
                    control_next = {8'h00, frame_byte};
                    phase_next   = PH_CTL1;
                end
                PH_CTL1:
                begin
                    control_next = {frame_byte, control_reg[7:0]};
                    phase_next   = PH_SEQ;
                end
                PH_SEQ:
                begin
                    seqno_next = frame_byte;
                    pos_next   = 3'd0;
                    phase_next = (dest_mode(control_reg) != AM_NONE) ? PH_DPAN
                                                                     : source_start(control_reg);
                end
                PH_DPAN:
                begin
                    dest_pan_next = dest_pan_reg | ({8'h00, frame_byte} << {pos_reg[0], 3'b000});
                    if (pos_inc >= 4'd2)
                    begin
                        pos_next   = 3'd0;
                        phase_next = PH_DADDR;
                    end
                    else
                        pos_next = pos_inc[2:0];
                end
                PH_DADDR:
                begin
                    dest_addr_next = dest_addr_reg | ({56'd0, frame_byte} << {pos_reg, 3'b000});
                    if (pos_inc >= addr_len(dest_mode(control_reg)))
                    begin
                        pos_next   = 3'd0;
                        phase_next = source_start(control_reg);
                    end
                    else
                        pos_next = pos_inc[2:0];
                end
                PH_SPAN:
                begin
                    source_pan_next = source_pan_reg
                                    | ({8'h00, frame_byte} << {pos_reg[0], 3'b000});
                    if (pos_inc >= 4'd2)
                    begin
                        pos_next   = 3'd0;
                        phase_next = PH_SADDR;
                    end
                    else
                        pos_next = pos_inc[2:0];
                end
                PH_SADDR:
                begin
                    source_addr_next = source_addr_reg
                                     | ({56'd0, frame_byte} << {pos_reg, 3'b000});
                    if (pos_inc >= addr_len(src_mode(control_reg)))
                    begin
                        pos_next   = 3'd0;
                        phase_next = PH_PAYLOAD;
                    end
                    else
                        pos_next = pos_inc[2:0];
                end
                PH_PAYLOAD:
                begin
                    // Without an FCS and with an empty delay line the byte goes straight out.
                    if (!fcs_present_reg && fill_reg == 2'd0)
                    begin
                        emit      = 1'b1;
                        emit_byte = frame_byte;
                    end
                    else if (fill_reg >= 2'd2)
                    begin
                        emit       = 1'b1;
                        emit_byte  = tail0_reg;
                        tail0_next = tail1_reg;
                        tail1_next = frame_byte;
                    end
                    else
                    begin
                        if (fill_reg[0])
                            tail1_next = frame_byte;
                        else
                            tail0_next = frame_byte;
                        fill_next = fill_reg + 2'd1;
                    end
                end
            endcase

            if (emit)
            begin
                if (count_reg >= 8'(MAX_PAYLOAD))
                    too_long_next = 1'b1;
                if (count_reg != 8'hff)
                    count_next = count_reg + 8'd1;
                pay_res.kind         = KIND_PAYLOAD;
                pay_res.payload_byte = emit_byte;
            end

            if (frame_end)
            begin
                sum_res.kind            = KIND_SUMMARY;
                sum_res.control_word    = control_next;
                sum_res.sequence_number = seqno_next;
                sum_res.dest_pan        = dest_pan_next;
                sum_res.dest_address    = dest_addr_next;
                sum_res.source_pan      = (src_mode(control_next) != AM_NONE
                                           && pan_comp(control_next)) ? dest_pan_next
                                                                      : source_pan_next;
                sum_res.source_address  = source_addr_next;
                sum_res.payload_length  = count_next;
                if (fcs_present_reg && fill_next >= 2'd2)
                    sum_res.check_sequence = {tail0_next, tail1_next};

                priority if (phase_next != PH_PAYLOAD)
                    sum_res.status = ST_TRUNC;
                else if (security_on(control_next))
                    sum_res.status = ST_SECURITY;
                else if (too_long_next)
                    sum_res.status = ST_TOO_LONG;
                else if (fcs_present_reg && fill_next < 2'd2)
                    sum_res.status = ST_TRUNC;
                else
                    sum_res.status = ST_OK;

                // Every frame starts from a clean state.
                phase_next       = PH_CTL0;
                pos_next         = 3'd0;
                control_next     = '0;
                seqno_next       = '0;
                dest_pan_next    = '0;
                dest_addr_next   = '0;
                source_pan_next  = '0;
                source_addr_next = '0;
                fill_next        = 2'd0;
                count_next       = '0;
                too_long_next    = 1'b0;
            end

            // The payload beat, when there is one, always goes ahead of the summary.
            if (emit)
            begin
                push.push0 = 1'b1;
                push.res0  = pay_res;
                push.push1 = frame_end;
                push.res1  = sum_res;
            end
            else
            begin
                push.push0 = frame_end;
                push.res0  = sum_res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fcs_present_reg <= 1'b1;
            phase_reg       <= PH_CTL0;
            pos_reg         <= '0;
            control_reg     <= '0;
            seqno_reg       <= '0;
            dest_pan_reg    <= '0;
            dest_addr_reg   <= '0;
            source_pan_reg  <= '0;
            source_addr_reg <= '0;
            fill_reg        <= '0;
            count_reg       <= '0;
            too_long_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                fcs_present_reg <= cfg_wdata;
            phase_reg       <= phase_next;
            pos_reg         <= pos_next;
            control_reg     <= control_next;
            seqno_reg       <= seqno_next;
            dest_pan_reg    <= dest_pan_next;
            dest_addr_reg   <= dest_addr_next;
            source_pan_reg  <= source_pan_next;
            source_addr_reg <= source_addr_next;
            fill_reg        <= fill_next;
            count_reg       <= count_next;
            too_long_reg    <= too_long_next;
        end
    end

    // Delay line bytes are only read after they have been written.
    always_ff @(posedge clk)
    begin
        tail0_reg <= tail0_next;
        tail1_reg <= tail1_next;
    end

endmodule

`default_nettype wire

### rtl/mfhp_outq.sv
// Three-slot result queue; slot 0 is the output register.
`default_nettype none

module mfhp_outq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mfhp_pkg::push_t push,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output mfhp_pkg::result_t    out_res
);
    import mfhp_pkg::*;

    localparam int unsigned SLOTS = 3;

    result_t    slot_reg [SLOTS];
    result_t    slot_next [SLOTS];
    logic [1:0] count_reg, count_next;
    logic [1:0] base;
    logic       pop;

    assign out_valid = (count_reg != 2'd0);
    assign out_res   = slot_reg[0];
    // Room for two beats is kept so a frame's last byte always has room for both its beats.
    assign in_ready  = (count_reg <= 2'd1);
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        base = count_reg - {1'b0, pop};
        for (int i = 0; i < SLOTS; i++)
        begin
            if (pop && i < SLOTS - 1)
                slot_next[i] = slot_reg[i + 1];
            else
                slot_next[i] = slot_reg[i];
            if (push.push0 && base == 2'(i))
                slot_next[i] = push.res0;
            else if (push.push1 && base + 2'd1 == 2'(i))
                slot_next[i] = push.res1;
        end
        count_next = base + {1'b0, push.push0} + {1'b0, push.push1};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SLOTS; i++)
            slot_reg[i] <= slot_next[i];
    end

endmodule

`default_nettype wire

### rtl/mac_frame_header_parser.sv
// Top level of the 802.15.4 MAC frame header parser.
//
// The slave channel takes one frame byte per beat in s_tdata, with s_tlast on
// the last byte of the frame. The master channel gives payload bytes
// (m_tuser 0) and, after the frame's last byte, one frame summary (m_tuser 1)
// with the header fields, payload length, captured FCS and status.
// A byte is parsed in the cycle it is accepted; its results are registered in
// the result queue for the master side. While s_tready is high, one byte per
// cycle is accepted back to back; the frame's last byte may produce two
// beats, a payload byte and the summary. Payload bytes pass a two-byte delay
// line while an FCS is expected. A three-beat result queue sets the rate:
// s_tready is high while it holds at most one beat, so a receiver stall backs
// up into s_tready after two beats have piled up. A last byte that yields two
// beats drops s_tready for one cycle even while m_tready stays high. cfg_we
// writes cfg_wdata into the FCS-present flag, which is sampled on every byte.
// Reset empties the queue, restarts parsing at the frame control field and
// sets the FCS-present flag.
`default_nettype none

module mac_frame_header_parser #(
    parameter int unsigned MAX_PAYLOAD = mfhp_pkg::MAX_PAYLOAD
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic         cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // frame_byte[7:0]
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // payload_byte[7:0], control_word[23:8], sequence_number[31:24],
    // dest_pan[47:32], dest_address[111:48], source_pan[127:112],
    // source_address[191:128], payload_length[199:192],
    // check_sequence[215:200], status[217:216], zero fill above
    output logic [223:0]      m_tdata,
    output logic              m_tuser    // kind
);
    import mfhp_pkg::*;

    logic    accept;
    push_t   push;
    result_t res;

    assign accept = s_tvalid && s_tready;

    mfhp_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .accept     (accept),
        .frame_byte (s_tdata),
        .frame_end  (s_tlast),
        .push       (push)
    );

    mfhp_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tuser = res.kind;
    assign m_tdata = {6'd0, res.status, res.check_sequence, res.payload_length,
                      res.source_address, res.source_pan, res.dest_address,
                      res.dest_pan, res.sequence_number, res.control_word,
                      res.payload_byte};

endmodule

`default_nettype wire

### test/tb_mac_frame_header_parser.sv
// Self-checking testbench for the 802.15.4 MAC frame header parser.
`default_nettype none

module tb_mac_frame_header_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import mfhp_pkg::*;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic         cfg_wdata = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'h00;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [223:0] m_tdata;
    logic         m_tuser;

    mac_frame_header_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("** mac_frame_header_parser: FAILED **");
        $finish;
    end

    // Parser state as the testbench sees it.
    logic         fcs_flag = 1'b1;
    phase_t       p_phase = PH_CTL0;
    logic [3:0]   p_pos = '0;
    logic [15:0]  p_ctl = '0;
    logic [7:0]   p_seq = '0;
    logic [15:0]  p_dpan = '0;
    logic [63:0]  p_daddr = '0;
    logic [15:0]  p_span = '0;
    logic [63:0]  p_saddr = '0;
    logic [7:0]   hold_a = '0;
    logic [7:0]   hold_b = '0;
    logic [1:0]   hold_cnt = '0;
    logic [7:0]   pay_cnt = '0;
    logic         too_long = 1'b0;

    result_t parsed_results[$];
    int mismatches = 0;
    int bytes_taken = 0;
    int burst_left = 0;
    int long_frames = 0;
    bit long_hold_done = 1'b0;

    function automatic logic [3:0] addr_bytes(input logic [1:0] mode);
        logic [3:0] n;
        if (mode == AM_NONE)
            n = 4'd0;
        else if (mode == AM_SHORT)
            n = 4'd2;
        else
            n = 4'd8;
        return n;
    endfunction

    function automatic phase_t first_source_phase(input logic [15:0] ctl);
        phase_t ph;
        if (ctl[15:14] == AM_NONE)
            ph = PH_PAYLOAD;
        else if (ctl[6])
            ph = PH_SADDR;
        else
            ph = PH_SPAN;
        return ph;
    endfunction

    task automatic clear_frame_state();
        p_phase = PH_CTL0;
        p_pos = '0;
        p_ctl = '0;
        p_seq = '0;
        p_dpan = '0;
        p_daddr = '0;
        p_span = '0;
        p_saddr = '0;
        hold_a = '0;
        hold_b = '0;
        hold_cnt = '0;
        pay_cnt = '0;
        too_long = 1'b0;
    endtask

    task automatic stream_payload(input logic [7:0] b);
        result_t r;
        r = '0;
        r.kind = KIND_PAYLOAD;
        r.payload_byte = b;
        r.status = ST_OK;
        parsed_results.push_back(r);
        if (pay_cnt >= MAX_PAYLOAD[7:0])
            too_long = 1'b1;
        if (pay_cnt != 8'hff)
            pay_cnt = pay_cnt + 8'd1;
    endtask

    // Parses one accepted byte and queues the beats it causes. A status given
    // by the directed table replaces the computed one.
    task automatic parse_byte(input logic [7:0] b, input logic l,
                              input logic use_st, input status_t st_given);
        result_t r;
        case (p_phase)
            PH_CTL0:
            begin
                p_ctl = {8'h00, b};
                p_phase = PH_CTL1;
            end
            PH_CTL1:
            begin
                p_ctl[15:8] = b;
                p_phase = PH_SEQ;
            end
            PH_SEQ:
            begin
                p_seq = b;
                p_pos = '0;
                p_phase = (p_ctl[11:10] != AM_NONE) ? PH_DPAN : first_source_phase(p_ctl);
            end
            PH_DPAN:
            begin
                p_dpan[8*p_pos[0] +: 8] = b;
                p_pos = p_pos + 4'd1;
                if (p_pos >= 4'd2)
                begin
                    p_pos = '0;
                    p_phase = PH_DADDR;
                end
            end
            PH_DADDR:
            begin
                p_daddr[8*p_pos[2:0] +: 8] = b;
                p_pos = p_pos + 4'd1;
                if (p_pos >= addr_bytes(p_ctl[11:10]))
                begin
                    p_pos = '0;
                    p_phase = first_source_phase(p_ctl);
                end
            end
            PH_SPAN:
            begin
                p_span[8*p_pos[0] +: 8] = b;
                p_pos = p_pos + 4'd1;
                if (p_pos >= 4'd2)
                begin
                    p_pos = '0;
                    p_phase = PH_SADDR;
                end
            end
            PH_SADDR:
            begin
                p_saddr[8*p_pos[2:0] +: 8] = b;
                p_pos = p_pos + 4'd1;
                if (p_pos >= addr_bytes(p_ctl[15:14]))
                begin
                    p_pos = '0;
                    p_phase = PH_PAYLOAD;
                end
            end
            default:
            begin
                // Payload bytes pass a two-byte delay unless no FCS is expected
                // and nothing is held.
                if (!fcs_flag && hold_cnt == 2'd0)
                    stream_payload(b);
                else if (hold_cnt >= 2'd2)
                begin
                    stream_payload(hold_a);
                    hold_a = hold_b;
                    hold_b = b;
                end
                else
                begin
                    if (hold_cnt[0])
                        hold_b = b;
                    else
                        hold_a = b;
                    hold_cnt = hold_cnt + 2'd1;
                end
            end
        endcase

        if (l)
        begin
            r = '0;
            r.kind = KIND_SUMMARY;
            r.control_word = p_ctl;
            r.sequence_number = p_seq;
            r.dest_pan = p_dpan;
            r.dest_address = p_daddr;
            r.source_pan = (p_ctl[15:14] != AM_NONE && p_ctl[6]) ? p_dpan : p_span;
            r.source_address = p_saddr;
            r.payload_length = pay_cnt;
            if (fcs_flag && hold_cnt >= 2'd2)
                r.check_sequence = {hold_a, hold_b};
            if (p_phase != PH_PAYLOAD)
                r.status = ST_TRUNC;
            else if (p_ctl[3])
                r.status = ST_SECURITY;
            else if (too_long)
                r.status = ST_TOO_LONG;
            else if (fcs_flag && hold_cnt < 2'd2)
                r.status = ST_TRUNC;
            else
                r.status = ST_OK;
            if (use_st)
                r.status = st_given;
            parsed_results.push_back(r);
            clear_frame_state();
        end
    endtask

    // Offers one byte, idling between bursts, and returns at the edge that
    // takes it.
    task automatic send_byte(input logic [7:0] b, input logic l,
                             input logic use_st, input status_t st_given);
        int idle;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            idle = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (idle != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (idle) @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= l;
        @(negedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
            @(negedge clk);
        end
        parse_byte(b, l, use_st, st_given);
        bytes_taken++;
        burst_left--;
        @(posedge clk);
    endtask

    // Lets every pending beat come out, then writes the FCS-present flag.
    task automatic settle_and_write(input logic v);
        s_tvalid <= 1'b0;
        while (parsed_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        fcs_flag = v;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    // A beat moves at the next rising edge when both sides are high here.
    always @(negedge clk)
    begin : beat_monitor
        result_t want;
        if (rst_n && m_tvalid === 1'b1 && m_tready)
        begin
            if (parsed_results.size() == 0)
            begin
                $error("beat with nothing pending: kind %0b, data %0h", m_tuser, m_tdata);
                mismatches++;
            end
            else
            begin
                want = parsed_results.pop_front();
                check_field("kind", 64'(want.kind), 64'(m_tuser));
                check_field("payload_byte", 64'(want.payload_byte), 64'(m_tdata[7:0]));
                check_field("control_word", 64'(want.control_word), 64'(m_tdata[23:8]));
                check_field("sequence_number", 64'(want.sequence_number),
                            64'(m_tdata[31:24]));
                check_field("dest_pan", 64'(want.dest_pan), 64'(m_tdata[47:32]));
                check_field("dest_address", want.dest_address, m_tdata[111:48]);
                check_field("source_pan", 64'(want.source_pan), 64'(m_tdata[127:112]));
                check_field("source_address", want.source_address, m_tdata[191:128]);
                check_field("payload_length", 64'(want.payload_length),
                            64'(m_tdata[199:192]));
                check_field("check_sequence", 64'(want.check_sequence),
                            64'(m_tdata[215:200]));
                check_field("status", 64'(want.status), 64'(m_tdata[217:216]));
            end
        end
    end

    // Receiver: switches between stall patterns, and once holds off long
    // enough that the parser backs up into s_tready.
    initial
    begin : receiver
        int k;
        int mode;
        k = 0;
        mode = 0;
        forever
        begin
            @(posedge clk);
            if (!long_hold_done && bytes_taken >= 300)
            begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else
            begin
                k++;
                if (k % 97 == 0)
                    mode = $urandom_range(0, 2);
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= (k % 4) != 3;
                    default: m_tready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    typedef struct packed {
        logic       wr;       // write the FCS flag before this byte
        logic       wv;
        logic [7:0] b;
        logic       l;
        logic       typed;    // status below is the expected one
        status_t    st;
    } stim_row_t;

    stim_row_t dir_rows [25] = '{
        // One-byte frame: header cut short.
        '{1'b0, 1'b0, 8'hFF, 1'b1, 1'b1, ST_TRUNC},
        // Security bit set; it wins over the missing FCS.
        '{1'b0, 1'b0, 8'h08, 1'b0, 1'b0, ST_OK},
        '{1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},
        '{1'b0, 1'b0, 8'h03, 1'b1, 1'b1, ST_SECURITY},
        // Short addresses with PAN compression, no payload, FCS 0x00FF.
        '{1'b0, 1'b0, 8'h40, 1'b0, 1'b0, ST_OK},
        '{1'b0, 1'b0, 8'h88, 1'b0, 1'b0, ST_OK},
        '{1'b0, 1'b0, 8'hFF, 1'b0, 1'b0, ST_OK},
        '{1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},
        '{1'b0, 1'b0, 8'hFF, 1'b0, 1'b0, ST_OK},
        '{1'b0, 1'b0, 8'hFF, 1'b0, 1'b0, ST_OK},
        '{1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},
        '{1'b0, 1'b0, 8'h12, 1'b0, 1'b0, ST_OK},
        '{1'b0, 1'b0, 8'h34, 1'b0, 1'b0, ST_OK},
        '{1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},
        '{1'b0, 1'b0, 8'hFF, 1'b1, 1'b1, ST_OK},
        // FCS flag cleared mid-frame: one held byte streams; the other and the last byte are dropped.
        '{1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},
        '{1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},
        '{1'b0, 1'b0, 8'h01, 1'b0, 1'b0, ST_OK},
        '{1'b0, 1'b0, 8'hAA, 1'b0, 1'b0, ST_OK},
        '{1'b0, 1'b0, 8'hBB, 1'b0, 1'b0, ST_OK},
        '{1'b1, 1'b0, 8'hCC, 1'b1, 1'b1, ST_OK},
        // FCS expected but only one byte after the header.
        '{1'b1, 1'b1, 8'h00, 1'b0, 1'b0, ST_OK},
        '{1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},
        '{1'b0, 1'b0, 8'h02, 1'b0, 1'b0, ST_OK},
        '{1'b0, 1'b0, 8'h55, 1'b1, 1'b1, ST_TRUNC}
    };

    initial
    begin : stimulus
        logic [7:0]  frame_q[$];
        logic [15:0] ctl;
        int hdr_len;
        int pay_len;
        int total;
        int split_at;
        int waited;
        logic [1:0] dm;
        logic [1:0] sm;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].wr)
                settle_and_write(dir_rows[i].wv);
            send_byte(dir_rows[i].b, dir_rows[i].l, dir_rows[i].typed, dir_rows[i].st);
        end

        settle_and_write(1'b0);
        while (bytes_taken < 1225)
        begin
            if ($urandom_range(0, 5) == 0)
                settle_and_write(1'($urandom_range(0, 1)));
            frame_q.delete();
            split_at = 0;
            if ($urandom_range(0, 9) == 0)
            begin
                // Noise: random bytes, usually a cut-off header.
                repeat ($urandom_range(1, 10))
                    frame_q.push_back(8'($urandom()));
            end
            else
            begin
                ctl = 16'($urandom());
                if ($urandom_range(0, 9) != 0)
                    ctl[3] = 1'b0;
                dm = ctl[11:10];
                sm = ctl[15:14];
                hdr_len = 3;
                if (dm != AM_NONE)
                    hdr_len += 2 + addr_bytes(dm);
                if (sm != AM_NONE)
                    hdr_len += (ctl[6] ? 0 : 2) + addr_bytes(sm);
                if (long_frames < 4 && $urandom_range(0, 29) == 0)
                begin
                    long_frames++;
                    pay_len = $urandom_range(250, 300);
                end
                else
                    pay_len = $urandom_range(0, 24);
                total = hdr_len + pay_len + (fcs_flag ? 2 : 0);
                if ($urandom_range(0, 7) == 0)
                    total = $urandom_range(1, total);
                frame_q.push_back(ctl[7:0]);
                frame_q.push_back(ctl[15:8]);
                while (frame_q.size() < total)
                    frame_q.push_back(8'($urandom()));
                while (frame_q.size() > total)
                    void'(frame_q.pop_back());
                if (total > 1 && $urandom_range(0, 5) == 0)
                    split_at = $urandom_range(1, total - 1);
            end
            foreach (frame_q[i])
            begin
                if (split_at != 0 && i == split_at)
                    settle_and_write(1'($urandom_range(0, 1)));
                send_byte(frame_q[i], i == frame_q.size() - 1, 1'b0, ST_OK);
            end
        end

        s_tvalid <= 1'b0;
        waited = 0;
        while (parsed_results.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        if (parsed_results.size() != 0)
        begin
            $error("%0d beats never arrived", parsed_results.size());
            mismatches++;
        end
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("** mac_frame_header_parser: PASSED **");
        else
            $display("** mac_frame_header_parser: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
